>>> hdl/ssr_pkg.sv
// Shared types and constants of the stream substring replace unit.
package ssr_pkg;

  localparam int unsigned MaxPattern     = 8;
  localparam int unsigned MaxReplacement = 8;
  localparam int unsigned ApbAddrW       = 5;
  localparam int unsigned ApbDataW       = 64;

  typedef enum logic [1:0] {
    RegPatLen   = 2'd0,
    RegPatBytes = 2'd1,
    RegRepLen   = 2'd2,
    RegRepBytes = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [3:0]  pattern_length;
    logic [63:0] pattern_bytes;
    logic [3:0]  replacement_length;
    logic [63:0] replacement_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       flush_after;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // One burst of result bytes, first byte in the lowest eight bits.
  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  len;
  } run_t;

endpackage

>>> hdl/ssr_cfg_regs.sv
// APB configuration registers of the stream substring replace unit.
module ssr_cfg_regs import ssr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q;
  cfg_reg_e reg_sel;
  logic     wr_en;

  assign reg_sel = cfg_reg_e'(paddr[4:3]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegPatLen:   cfg_q.pattern_length     <= pwdata[3:0];
        RegPatBytes: cfg_q.pattern_bytes      <= pwdata;
        RegRepLen:   cfg_q.replacement_length <= pwdata[3:0];
        RegRepBytes: cfg_q.replacement_bytes  <= pwdata;
        default:     cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegPatLen:   prdata = {60'd0, cfg_q.pattern_length};
      RegPatBytes: prdata = cfg_q.pattern_bytes;
      RegRepLen:   prdata = {60'd0, cfg_q.replacement_length};
      RegRepBytes: prdata = cfg_q.replacement_bytes;
      default:     prdata = '0;
    endcase
  end

endmodule

>>> hdl/ssr_window.sv
// Input register, pending-byte window and match logic producing one burst per item.
module ssr_window import ssr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  logic     run_free_i,
  output logic     run_load_o,
  output run_t     run_o
);

  logic                 in_valid_q;
  in_item_t             in_q;
  logic [7:0][7:0]      win_q, win_d;
  logic [2:0]           win_cnt_q, win_cnt_d;

  logic [7:0][7:0]      win_app;
  logic [7:0][7:0]      pat;
  logic [3:0]           plen, rlen, cnt1, take;
  logic                 match, use_rep, advance;
  logic [3:0]           src_idx [8];

  assign pat  = cfg_i.pattern_bytes;
  assign plen = (cfg_i.pattern_length > 4'(MaxPattern)) ? 4'(MaxPattern)
                                                         : cfg_i.pattern_length;
  assign rlen = (cfg_i.replacement_length > 4'(MaxReplacement)) ? 4'(MaxReplacement)
                                                                 : cfg_i.replacement_length;
  assign cnt1 = {1'b0, win_cnt_q} + 4'd1;

  assign advance    = in_valid_q && run_free_i;
  assign in_ready_o = !in_valid_q || run_free_i;
  assign run_load_o = advance;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      win_app[k] = (3'(k) == win_cnt_q) ? in_q.text_byte : win_q[k];
    end
    // Bytes past the pattern length always compare equal.
    match = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if ((4'(k) < plen) && (win_app[k] != pat[k])) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    use_rep = 1'b0;
    take    = 4'd0;
    if (plen == 4'd0) begin
      take = cnt1;
    end else if (cnt1 > plen) begin
      // Pattern shrank: drain until fewer than the pattern length remain.
      take = cnt1 - plen + 4'd1;
    end else if (cnt1 == plen) begin
      if (match) begin
        use_rep = 1'b1;
      end else begin
        take = 4'd1;
      end
    end
    if (in_q.flush_after && !use_rep) begin
      take = cnt1;
    end

    run_o.bytes = use_rep ? cfg_i.replacement_bytes : 64'(win_app);
    run_o.len   = use_rep ? rlen : take;

    for (int k = 0; k < 8; k++) begin
      src_idx[k] = 4'(k) + take;
      win_d[k]   = (src_idx[k] < 4'd8) ? win_app[src_idx[k][2:0]] : 8'd0;
    end
    win_cnt_d = use_rep ? 3'd0 : 3'(cnt1 - take);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      win_cnt_q  <= 3'd0;
      win_q      <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        win_cnt_q <= win_cnt_d;
        win_q     <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // A flushed line leaves nothing pending.
  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.flush_after |=> win_cnt_q == 3'd0)
    else $error("window not empty after a flush");

  // A zero pattern length passes every byte through at once.
  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && plen == 4'd0 |-> run_o.len == cnt1 && win_cnt_d == 3'd0)
    else $error("pass-through left bytes pending");

endmodule

>>> hdl/ssr_emitter.sv
// Result register that sends one burst out a byte per transfer.
module ssr_emitter import ssr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      run_load_i,
  input  run_t      run_i,
  output logic      run_free_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic [63:0] bytes_q;
  logic [3:0]  len_q;
  logic        xfer;

  assign out_valid_o            = (len_q != 4'd0);
  assign xfer                   = out_valid_o && out_ready_i;
  assign run_free_o             = (len_q == 4'd0) || (xfer && len_q == 4'd1);
  assign out_data_o.out_byte    = bytes_q[7:0];
  assign out_data_o.last_of_run = (len_q == 4'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= 4'd0;
    end else if (run_load_i) begin
      len_q <= run_i.len;
    end else if (xfer) begin
      len_q <= len_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_load_i) begin
      bytes_q <= run_i.bytes;
    end else if (xfer) begin
      bytes_q <= {8'd0, bytes_q[63:8]};
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_load_i |-> run_free_o)
    else $error("burst loaded over a pending burst");

  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && !out_data_o.last_of_run |=> out_valid_o && len_q == $past(len_q) - 4'd1)
    else $error("burst ended before its last byte");

endmodule

>>> hdl/stream_substring_replace_unit.sv
// Top level of the stream substring replace unit.
//
// Text bytes enter on the in_ channel (valid/ready), each with a flush flag that
// marks a line end. Rewritten bytes leave on the out_ channel; last_of_run marks
// the final byte caused by one input transfer. An input that causes no output
// produces no transfer at all. Pattern and replacement are set through the APB
// port (registers at byte addresses 0, 8, 16 and 24, 64-bit data, pready always
// high). The user must write them only while the stream is idle; the block
// itself does not enforce this. An accepted byte is registered in the input
// register, where the window and pattern compare build its whole burst; the
// burst is then loaded into the result register, which sends its bytes out
// one byte per cycle while the receiver is ready; a burst holds at most 8
// bytes. A new input is taken every cycle while bursts are a single byte or
// empty and the receiver is ready.
// Reset clears the window, the configuration and both valid flags. When the
// receiver stalls, the current byte holds and the input register fills, after
// which in_ready_o drops until the burst drains.
module stream_substring_replace_unit import ssr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t cfg;
  run_t run;
  logic run_load;
  logic run_free;

  ssr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ssr_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .run_free_i (run_free),
    .run_load_o (run_load),
    .run_o      (run)
  );

  ssr_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_load_i  (run_load),
    .run_i       (run),
    .run_free_o  (run_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
